// File: rtl/cube_grid_face_cull_mesher_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the culled cube mesher
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CUBE_GRID_FACE_CULL_MESHER_DEFINES_SVH
`define CUBE_GRID_FACE_CULL_MESHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGFCM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CGFCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cgfcm_pkg.sv
// ---------------------------------------------------------------------------
// Culled cube mesher package
// Opcodes, face codes and the constant corner tables of the unit cube.
// ---------------------------------------------------------------------------
package cgfcm_pkg;

  localparam int GRID_EDGE_DEF = 16;
  localparam int FACE_COUNT    = 6;
  localparam logic [15:0] SCALE_RESET = 16'd100;
  localparam logic [1:0]  SLOT_LAST   = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_MESH    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    FACE_POS_Z = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_POS_X = 3'd3,
    FACE_NEG_Y = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic signed [1:0] dz;
  } delta_t;

  // Corner offsets of the unit cube, packed as {dx, dy, dz}.
  localparam logic [2:0] CORNER_OFF [8] = '{
    3'b011, 3'b111, 3'b101, 3'b001, 3'b010, 3'b110, 3'b100, 3'b000
  };

  // Corner order of each face quad.
  localparam logic [2:0] FACE_CORNERS [FACE_COUNT][4] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd4, 3'd0, 3'd3, 3'd7},
    '{3'd5, 3'd1, 3'd0, 3'd4},
    '{3'd6, 3'd2, 3'd1, 3'd5},
    '{3'd7, 3'd3, 3'd2, 3'd6},
    '{3'd7, 3'd6, 3'd5, 3'd4}
  };

  function automatic delta_t face_delta(input face_t face);
    delta_t d;
    d = '0;
    case (face)
      FACE_POS_Z: d.dz = 2'sd1;
      FACE_NEG_X: d.dx = -2'sd1;
      FACE_POS_Y: d.dy = 2'sd1;
      FACE_POS_X: d.dx = 2'sd1;
      FACE_NEG_Y: d.dy = -2'sd1;
      FACE_NEG_Z: d.dz = -2'sd1;
      default:    d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] corner_offset(input logic [2:0] face,
                                               input logic [1:0] slot);
    logic [2:0] res;
    res = 3'b000;
    if (int'(face) < FACE_COUNT) begin
      res = CORNER_OFF[FACE_CORNERS[face][slot]];
    end
    return res;
  endfunction

endpackage

// File: rtl/cgfcm_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module cgfcm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/cube_grid_face_cull_mesher.sv
// ---------------------------------------------------------------------------
// Culled cube mesher
// Occupancy grid in a one-bit RAM; emits the exposed face quads of a cell.
// ---------------------------------------------------------------------------
// Input transactions (valid/ready) carry an opcode and a cell coordinate. A
// write stores the cell's occupancy, a restart zeroes the vertex counter. A
// mesh transaction reads the cell and its six neighbours through the single
// read port of the occupancy RAM, one address a cycle. Each exposed face of a
// solid cell then yields four vertex transactions, one per cycle while the
// receiver keeps up. Hidden faces ahead of the last exposed one are scanned
// and skipped, and all six are when none is exposed. The block takes one
// item at a time; in_ready is high only between items. The output register
// decouples the sides: when the receiver stalls, emission pauses with the
// vertex held, and the next item is taken as soon as the final vertex of the
// current one has been loaded. After reset the block sweeps the RAM to empty,
// all 2^(3*ceil(log2(GRID_EDGE))) cells (4096 at the default edge), one cell
// a cycle, with in_ready low. The scale register is to be written between
// items, also during the sweep; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`include "cube_grid_face_cull_mesher_defines.svh"

module cube_grid_face_cull_mesher #(
  parameter int GRID_EDGE = cgfcm_pkg::GRID_EDGE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_cell_x,
  input  logic [3:0]  in_cell_y,
  input  logic [3:0]  in_cell_z,
  input  logic        in_solid_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_face_dir,
  output logic [1:0]  out_corner_slot,
  output logic [19:0] out_pos_x,
  output logic [19:0] out_pos_y,
  output logic [19:0] out_pos_z,
  output logic [16:0] out_vertex_index,
  output logic        out_last
);

  import cgfcm_pkg::*;

  localparam int AW    = $clog2(GRID_EDGE);
  localparam int RAW   = 3 * AW;
  localparam int DEPTH = 1 << RAW;

  localparam logic [2:0] STEP_CENTRE = 3'd0;
  localparam logic [2:0] STEP_LAST   = 3'd6;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_WAIT,
    S_EMIT
  } state_t;

  function automatic logic coord_ok(input logic signed [5:0] c);
    return !c[5] && (int'(c[4:0]) < GRID_EDGE);
  endfunction

  state_t           state_r;
  logic [RAW-1:0]   clr_addr_r;
  logic [15:0]      cell_scale_r;
  logic [16:0]      vcount_r;
  logic [3:0]       cur_x_r, cur_y_r, cur_z_r;
  logic [2:0]       step_r;
  logic             cap_vld_r;
  logic [2:0]       cap_step_r;
  logic             cap_inr_r;
  logic             center_r;
  logic [5:0]       expose_r;
  logic [2:0]       face_r;
  logic [1:0]       slot_r;

  logic             out_valid_r;
  logic [2:0]       out_face_r;
  logic [1:0]       out_slot_r;
  logic [19:0]      out_pos_x_r, out_pos_y_r, out_pos_z_r;
  logic [16:0]      out_index_r;
  logic             out_last_r;

  // Handshake and RAM signals.
  logic             in_fire;
  logic             in_inr;
  logic [RAW-1:0]   in_addr;
  logic             ram_we;
  logic [RAW-1:0]   ram_waddr;
  logic [0:0]       ram_wdata;
  logic [RAW-1:0]   look_addr;
  logic [0:0]       ram_rdata;
  logic             look_inr;
  delta_t           dlt;
  logic signed [5:0] nx, ny, nz;

  // Vertex generation.
  logic             out_load;
  logic             vtx_load;
  logic             vtx_last;
  logic [5:0]       above;
  logic [2:0]       off;
  logic [4:0]       px, py, pz;
  logic [20:0]      prod_x, prod_y, prod_z;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_inr   = (int'(in_cell_x) < GRID_EDGE) && (int'(in_cell_y) < GRID_EDGE) &&
                    (int'(in_cell_z) < GRID_EDGE);
  assign in_addr  = {AW'(in_cell_z), AW'(in_cell_y), AW'(in_cell_x)};

  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = in_fire && (in_opcode == OP_WRITE) && in_inr;
      ram_waddr = in_addr;
      ram_wdata = in_solid_in;
    end
  end

  // The centre cell is looked up first, then the neighbours in face order.
  always_comb begin
    dlt       = (step_r == STEP_CENTRE) ? '0 : face_delta(face_t'(step_r - 3'd1));
    nx        = $signed({2'b00, cur_x_r}) + 6'(dlt.dx);
    ny        = $signed({2'b00, cur_y_r}) + 6'(dlt.dy);
    nz        = $signed({2'b00, cur_z_r}) + 6'(dlt.dz);
    look_inr  = coord_ok(nx) && coord_ok(ny) && coord_ok(nz);
    look_addr = {AW'(nz[4:0]), AW'(ny[4:0]), AW'(nx[4:0])};
  end

  cgfcm_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_occ_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (look_addr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    out_load = !out_valid_r || out_ready;
    vtx_load = (state_r == S_EMIT) && expose_r[face_r] && out_load;
    above    = (expose_r >> face_r) >> 1;
    vtx_last = (slot_r == SLOT_LAST) && (above == 6'd0);
    off      = corner_offset(face_r, slot_r);
    px       = {1'b0, cur_x_r} + {4'b0000, off[2]};
    py       = {1'b0, cur_y_r} + {4'b0000, off[1]};
    pz       = {1'b0, cur_z_r} + {4'b0000, off[0]};
    prod_x   = 21'(px) * 21'(cell_scale_r);
    prod_y   = 21'(py) * 21'(cell_scale_r);
    prod_z   = 21'(pz) * 21'(cell_scale_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      cell_scale_r <= SCALE_RESET;
      vcount_r     <= '0;
      cap_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cell_scale_r <= cfg_wr_data;
      end

      // Read data arrives in the cycle after the address was issued.
      cap_vld_r <= 1'b0;
      if (cap_vld_r) begin
        if (cap_step_r == STEP_CENTRE) begin
          center_r <= ram_rdata[0] && cap_inr_r;
        end else begin
          expose_r[3'(cap_step_r - 3'd1)] <= !(ram_rdata[0] && cap_inr_r);
        end
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == {RAW{1'b1}}) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            case (in_opcode)
              OP_MESH: begin
                cur_x_r <= in_cell_x;
                cur_y_r <= in_cell_y;
                cur_z_r <= in_cell_z;
                step_r  <= STEP_CENTRE;
                state_r <= S_LOOK;
              end
              OP_RESTART: vcount_r <= '0;
              default: ;
            endcase
          end
        end
        S_LOOK: begin
          cap_vld_r  <= 1'b1;
          cap_step_r <= step_r;
          cap_inr_r  <= look_inr;
          if (step_r == STEP_LAST) begin
            state_r <= S_WAIT;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_WAIT: begin
          // The last neighbour lands in this cycle; the centre is already known.
          face_r <= FACE_POS_Z;
          slot_r <= '0;
          state_r <= center_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!expose_r[face_r]) begin
            if (face_r == FACE_NEG_Z) begin
              state_r <= S_IDLE;
            end else begin
              face_r <= face_r + 3'd1;
            end
          end else if (out_load) begin
            out_valid_r <= 1'b1;
            out_face_r  <= face_r;
            out_slot_r  <= slot_r;
            out_pos_x_r <= prod_x[19:0];
            out_pos_y_r <= prod_y[19:0];
            out_pos_z_r <= prod_z[19:0];
            out_index_r <= vcount_r;
            out_last_r  <= vtx_last;
            vcount_r    <= vcount_r + 17'd1;
            slot_r      <= slot_r + 2'd1;
            if (slot_r == SLOT_LAST) begin
              if (vtx_last) begin
                state_r <= S_IDLE;
              end else begin
                face_r <= face_r + 3'd1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_face_dir     = out_face_r;
  assign out_corner_slot  = out_slot_r;
  assign out_pos_x        = out_pos_x_r;
  assign out_pos_y        = out_pos_y_r;
  assign out_pos_z        = out_pos_z_r;
  assign out_vertex_index = out_index_r;
  assign out_last         = out_last_r;

  `CGFCM_ASSERT_SAME(a_no_write_in_lookup, state_r == S_LOOK, !ram_we, "RAM write during lookup")
  `CGFCM_ASSERT_NEXT(a_count_step, vtx_load, vcount_r == $past(vcount_r) + 17'd1, "vertex count slip")
  `CGFCM_ASSERT_SAME(a_last_slot, out_valid && out_last, out_corner_slot == SLOT_LAST, "last not on slot 3")
  `CGFCM_ASSERT_SAME(a_emit_solid, state_r == S_EMIT, center_r, "emitting for an empty cell")

endmodule

// File: tb/cube_grid_face_cull_mesher_tb.sv
// ---------------------------------------------------------------------------
// Testbench for the culled cube mesher
// A queue-fed driver sends write, mesh, restart and spare-opcode commands while
// a monitor checks every vertex against a local model of the grid, the vertex
// counter and the scale register. Both sides stall at random in several phases.
// ---------------------------------------------------------------------------
module cube_grid_face_cull_mesher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cgfcm_pkg::*;

  localparam int EDGE = GRID_EDGE_DEF;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int ISOLATED_MESHES = 4;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
    logic       solid;
  } cell_cmd_t;

  typedef struct packed {
    face_t       face;
    logic [1:0]  slot;
    logic [19:0] pos_x;
    logic [19:0] pos_y;
    logic [19:0] pos_z;
    logic [16:0] index;
    logic        last;
  } vertex_t;

  // Unit cube corners as {dx, dy, dz}, and the corner order of each face.
  localparam logic [2:0] CUBE_CORNER [8] = '{
    3'b011, 3'b111, 3'b101, 3'b001, 3'b010, 3'b110, 3'b100, 3'b000
  };
  localparam int QUAD_ORDER [6][4] = '{
    '{0, 1, 2, 3}, '{4, 0, 3, 7}, '{5, 1, 0, 4},
    '{6, 2, 1, 5}, '{7, 3, 2, 6}, '{7, 6, 5, 4}
  };
  localparam int NEIGHBOUR_STEP [6][3] = '{
    '{0, 0, 1}, '{-1, 0, 0}, '{0, 1, 0}, '{1, 0, 0}, '{0, -1, 0}, '{0, 0, -1}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = OP_WRITE;
  logic [3:0]  in_cell_x = '0;
  logic [3:0]  in_cell_y = '0;
  logic [3:0]  in_cell_z = '0;
  logic        in_solid_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_face_dir;
  logic [1:0]  out_corner_slot;
  logic [19:0] out_pos_x;
  logic [19:0] out_pos_y;
  logic [19:0] out_pos_z;
  logic [16:0] out_vertex_index;
  logic        out_last;

  cell_cmd_t pending_cmds [$];
  vertex_t   expected_vertices [$];

  bit          grid_model [EDGE*EDGE*EDGE];
  logic [16:0] vertex_counter = '0;
  logic [15:0] scale_model = SCALE_RESET;

  int send_idle_pct = 37;
  int recv_idle_pct = 59;
  int mismatch_count = 0;
  int cycle_count = 0;

  cube_grid_face_cull_mesher DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_cell_x        (in_cell_x),
    .in_cell_y        (in_cell_y),
    .in_cell_z        (in_cell_z),
    .in_solid_in      (in_solid_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_face_dir     (out_face_dir),
    .out_corner_slot  (out_corner_slot),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_vertex_index (out_vertex_index),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit cell_is_solid(input int x, input int y, input int z);
    if (x < 0 || y < 0 || z < 0 || x >= EDGE || y >= EDGE || z >= EDGE) begin
      return 1'b0;
    end
    return grid_model[(z * EDGE + y) * EDGE + x];
  endfunction

  function automatic logic [19:0] corner_pos(input int coord, input logic off);
    int unsigned prod;
    prod = (coord + off) * scale_model;
    return prod[19:0];
  endfunction

  // Updates the grid and counter for one accepted command and queues the
  // vertices that it should produce.
  task automatic predict_cell_cmd(input cell_cmd_t c);
    bit exposed [6];
    int last_face;
    logic [2:0] off;
    vertex_t v;
    last_face = -1;
    case (c.opcode)
      OP_WRITE: begin
        grid_model[(c.z * EDGE + c.y) * EDGE + c.x] = c.solid;
      end
      OP_RESTART: begin
        vertex_counter = '0;
      end
      OP_MESH: begin
        if (cell_is_solid(c.x, c.y, c.z)) begin
          for (int f = FACE_POS_Z; f <= FACE_NEG_Z; f++) begin
            exposed[f] = !cell_is_solid(c.x + NEIGHBOUR_STEP[f][0],
                                        c.y + NEIGHBOUR_STEP[f][1],
                                        c.z + NEIGHBOUR_STEP[f][2]);
            if (exposed[f]) begin
              last_face = f;
            end
          end
          for (int f = FACE_POS_Z; f <= FACE_NEG_Z; f++) begin
            if (exposed[f]) begin
              for (int s = 0; s < 4; s++) begin
                off = CUBE_CORNER[QUAD_ORDER[f][s]];
                v.face = face_t'(f);
                v.slot = s[1:0];
                v.pos_x = corner_pos(c.x, off[2]);
                v.pos_y = corner_pos(c.y, off[1]);
                v.pos_z = corner_pos(c.z, off[0]);
                v.index = vertex_counter;
                v.last = (f == last_face) && (s == 3);
                expected_vertices.push_back(v);
                vertex_counter = vertex_counter + 17'd1;
              end
            end
          end
        end
      end
      default: begin
        // The spare opcode leaves all state alone.
      end
    endcase
  endtask

  // Driver: presents the next pending command, holding it until accepted.
  always @(posedge clk) begin
    cell_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_cell_cmd('{in_opcode, in_cell_x, in_cell_y, in_cell_z, in_solid_in});
      end
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_opcode <= nxt.opcode;
        in_cell_x <= nxt.x;
        in_cell_y <= nxt.y;
        in_cell_z <= nxt.z;
        in_solid_in <= nxt.solid;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: every vertex transaction is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    vertex_t got;
    vertex_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.face = face_t'(out_face_dir);
        got.slot = out_corner_slot;
        got.pos_x = out_pos_x;
        got.pos_y = out_pos_y;
        got.pos_z = out_pos_z;
        got.index = out_vertex_index;
        got.last = out_last;
        if (expected_vertices.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected vertex: face %0d slot %0d pos (%0d,%0d,%0d) idx %0d last %0d",
                     got.face, got.slot, got.pos_x, got.pos_y, got.pos_z, got.index,
                     got.last);
          end
        end else begin
          want = expected_vertices.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("vertex mismatch: expected face %0d slot %0d pos (%0d,%0d,%0d) idx %0d last %0d",
                       want.face, want.slot, want.pos_x, want.pos_y, want.pos_z,
                       want.index, want.last);
              $display("                 actual   face %0d slot %0d pos (%0d,%0d,%0d) idx %0d last %0d",
                       got.face, got.slot, got.pos_x, got.pos_y, got.pos_z, got.index,
                       got.last);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cube_grid_face_cull_mesher_tb: done, errors");
      $finish;
    end
  end

  function automatic cell_cmd_t make_cmd(input logic [1:0] op, input int x, input int y,
                                         input int z, input bit s);
    cell_cmd_t c;
    c.opcode = op;
    c.x = x[3:0];
    c.y = y[3:0];
    c.z = z[3:0];
    c.solid = s;
    return c;
  endfunction

  function automatic int pick_region_base();
    case ($urandom_range(2))
      0: return 0;
      1: return EDGE - 3;
      default: return $urandom_range(EDGE - 3);
    endcase
  endfunction

  // Mostly writes and meshes inside a small moving block of cells, so that
  // neighbours are often solid; the rest is restarts, the spare opcode and
  // fully random commands.
  task automatic queue_random_cmds(input int count);
    int hx;
    int hy;
    int hz;
    int roll;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) begin
        hx = pick_region_base();
        hy = pick_region_base();
        hz = pick_region_base();
      end
      roll = $urandom_range(99);
      if (roll < 40) begin
        pending_cmds.push_back(make_cmd(OP_WRITE, hx + $urandom_range(2),
                                        hy + $urandom_range(2), hz + $urandom_range(2),
                                        $urandom_range(3) != 0));
      end else if (roll < 80) begin
        pending_cmds.push_back(make_cmd(OP_MESH, hx + $urandom_range(2),
                                        hy + $urandom_range(2), hz + $urandom_range(2),
                                        1'($urandom_range(1))));
      end else if (roll < 85) begin
        pending_cmds.push_back(make_cmd(OP_RESTART, $urandom_range(15), $urandom_range(15),
                                        $urandom_range(15), 1'($urandom_range(1))));
      end else if (roll < 90) begin
        pending_cmds.push_back(make_cmd(OP_UNUSED, $urandom_range(15), $urandom_range(15),
                                        $urandom_range(15), 1'($urandom_range(1))));
      end else begin
        pending_cmds.push_back(make_cmd(2'($urandom_range(3)), $urandom_range(15),
                                        $urandom_range(15), $urandom_range(15),
                                        1'($urandom_range(1))));
      end
    end
  endtask

  // Holds off until every command has gone in and every vertex has come
  // out, then lets the block finish any command that produces nothing.
  task automatic wait_until_drained();
    do begin
      @(negedge clk);
    end while (pending_cmds.size() != 0 || in_valid || expected_vertices.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_scale(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    scale_model = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset scale.
    pending_cmds.push_back(make_cmd(OP_MESH, 0, 0, 0, 1'b1));
    pending_cmds.push_back(make_cmd(OP_WRITE, 0, 0, 0, 1'b1));
    pending_cmds.push_back(make_cmd(OP_MESH, 0, 0, 0, 1'b0));
    pending_cmds.push_back(make_cmd(OP_WRITE, 15, 15, 15, 1'b1));
    pending_cmds.push_back(make_cmd(OP_MESH, 15, 15, 15, 1'b0));
    pending_cmds.push_back(make_cmd(OP_UNUSED, 1, 0, 0, 1'b1));
    pending_cmds.push_back(make_cmd(OP_MESH, 1, 0, 0, 1'b1));
    pending_cmds.push_back(make_cmd(OP_MESH, 0, 0, 0, 1'b1));
    pending_cmds.push_back(make_cmd(OP_RESTART, 15, 15, 15, 1'b1));
    pending_cmds.push_back(make_cmd(OP_MESH, 15, 15, 15, 1'b1));
    // A cell boxed in on all six sides yields no vertices.
    pending_cmds.push_back(make_cmd(OP_WRITE, 5, 5, 5, 1'b1));
    for (int f = FACE_POS_Z; f <= FACE_NEG_Z; f++) begin
      pending_cmds.push_back(make_cmd(OP_WRITE, 5 + NEIGHBOUR_STEP[f][0],
                                      5 + NEIGHBOUR_STEP[f][1], 5 + NEIGHBOUR_STEP[f][2],
                                      1'b1));
    end
    pending_cmds.push_back(make_cmd(OP_MESH, 5, 5, 5, 1'b0));
    pending_cmds.push_back(make_cmd(OP_MESH, 5, 5, 6, 1'b0));
    pending_cmds.push_back(make_cmd(OP_WRITE, 5, 5, 6, 1'b0));
    pending_cmds.push_back(make_cmd(OP_MESH, 5, 5, 5, 1'b0));
    wait_until_drained();

    write_scale(16'hFFFF);
    queue_random_cmds(50);
    wait_until_drained();

    send_idle_pct = 59;
    recv_idle_pct = 37;
    write_scale(16'h0000);
    queue_random_cmds(25);
    wait_until_drained();
    queue_random_cmds(25);
    wait_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_scale(16'h0001);
    queue_random_cmds(40);
    wait_until_drained();

    // A few meshes of an isolated cell at a random scale, each giving all
    // six faces, after a restart of the vertex counter.
    write_scale(16'($urandom_range(65535, 1)));
    pending_cmds.push_back(make_cmd(OP_WRITE, 8, 8, 8, 1'b1));
    for (int f = FACE_POS_Z; f <= FACE_NEG_Z; f++) begin
      pending_cmds.push_back(make_cmd(OP_WRITE, 8 + NEIGHBOUR_STEP[f][0],
                                      8 + NEIGHBOUR_STEP[f][1], 8 + NEIGHBOUR_STEP[f][2],
                                      1'b0));
    end
    pending_cmds.push_back(make_cmd(OP_RESTART, 0, 0, 0, 1'b0));
    for (int i = 0; i < ISOLATED_MESHES; i++) begin
      pending_cmds.push_back(make_cmd(OP_MESH, 8, 8, 8, 1'($urandom_range(1))));
    end
    wait_until_drained();

    if (mismatch_count == 0 && expected_vertices.size() == 0) begin
      $display("cube_grid_face_cull_mesher_tb: done, clean");
    end else begin
      $display("cube_grid_face_cull_mesher_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/cgfcm_pkg.sv
rtl/cgfcm_ram.sv
rtl/cube_grid_face_cull_mesher.sv
tb/cube_grid_face_cull_mesher_tb.sv
